[hw/rtl/sact_pkg.sv]
package sact_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = 11;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_SORT   = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] packet_count;
  } item_t;

  typedef struct packed {
    logic [31:0]        found_count;
    logic               found;
    logic [ENTRY_W-1:0] entries;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] count;
  } entry_t;

  typedef enum logic [3:0] {
    DP_NOP        = 4'd0,
    DP_CLEAR      = 4'd1,
    DP_APPEND     = 4'd2,
    DP_SORT_INIT  = 4'd3,
    DP_PASS_START = 4'd4,
    DP_PASS_LOAD  = 4'd5,
    DP_PASS_STEP  = 4'd6,
    DP_PASS_END   = 4'd7,
    DP_LK_INIT    = 4'd8,
    DP_LK_PROBE   = 4'd9,
    DP_LK_CMP     = 4'd10
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   fin;
  } dp_cmd_t;

  typedef struct packed {
    logic under_two;
    logic last_step;
    logic r_one;
    logic lk_empty;
    logic lk_hit;
  } dp_stat_t;

endpackage

[hw/rtl/sact_ctrl.sv]
module sact_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sact_pkg::kind_t    kind,
  input  sact_pkg::dp_stat_t stat,
  output sact_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import sact_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_S_START = 7'b0000010,
    ST_S_LOAD  = 7'b0000100,
    ST_S_STEP  = 7'b0001000,
    ST_S_END   = 7'b0010000,
    ST_L_PROBE = 7'b0100000,
    ST_L_CMP   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    cmd.fin    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (kind)
            KIND_CLEAR: begin
              cmd.op  = DP_CLEAR;
              cmd.fin = 1'b1;
            end
            KIND_APPEND: begin
              cmd.op  = DP_APPEND;
              cmd.fin = 1'b1;
            end
            KIND_SORT: begin
              if (stat.under_two) begin
                cmd.fin = 1'b1;
              end else begin
                cmd.op     = DP_SORT_INIT;
                state_next = ST_S_START;
              end
            end
            KIND_LOOKUP: begin
              cmd.op     = DP_LK_INIT;
              state_next = ST_L_PROBE;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_S_START: begin
        cmd.op     = DP_PASS_START;
        state_next = ST_S_LOAD;
      end
      ST_S_LOAD: begin
        cmd.op     = DP_PASS_LOAD;
        state_next = ST_S_STEP;
      end
      ST_S_STEP: begin
        cmd.op = DP_PASS_STEP;
        if (stat.last_step) begin
          state_next = ST_S_END;
        end
      end
      ST_S_END: begin
        cmd.op = DP_PASS_END;
        if (stat.r_one) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_S_START;
        end
      end
      ST_L_PROBE: begin
        cmd.op = DP_LK_PROBE;
        if (stat.lk_empty) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_L_CMP;
        end
      end
      ST_L_CMP: begin
        cmd.op = DP_LK_CMP;
        if (stat.lk_hit) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_L_PROBE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

`ifndef SYNTHESIS
  // every finishing beat hands the block back to idle
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> state == ST_IDLE)
    else $error("finish without return to idle");

  a_miss_probe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_L_CMP && !stat.lk_hit) |=> state == ST_L_PROBE)
    else $error("lookup miss did not narrow and probe again");
`endif

endmodule

[hw/rtl/sact_dp.sv]
module sact_dp (
  input  logic               clk,
  input  logic               rst,
  input  sact_pkg::item_t    item,
  input  sact_pkg::dp_cmd_t  cmd,
  output sact_pkg::dp_stat_t stat,
  output logic               done,
  output sact_pkg::result_t  result
);
  import sact_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata;
  entry_t carry;
  entry_t wr_data;

  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  lo, hi;
  logic [ADDR_W-1:0] r, idx, mid;
  logic [ADDR_W-1:0] idx_p1, idx_p2, mid_calc;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [CNT_W:0]    mid_sum;
  logic [31:0]       key;
  logic              rd_en, wr_en;
  logic              full, swap, hit;

  assign full     = (count == CNT_W'(DEPTH));
  assign swap     = (carry.key > rdata.key);
  assign idx_p1   = idx + ADDR_W'(1);
  assign idx_p2   = idx + ADDR_W'(2);
  // floor((lo + hi_incl) / 2) with hi kept exclusive
  assign mid_sum  = (CNT_W + 1)'(lo) + (CNT_W + 1)'(hi) - (CNT_W + 1)'(1);
  assign mid_calc = mid_sum[ADDR_W:1];
  assign hit      = (cmd.op == DP_LK_CMP) && (rdata.key == key);

  assign stat.under_two = (count < CNT_W'(2));
  assign stat.last_step = (idx_p1 == r);
  assign stat.r_one     = (r == ADDR_W'(1));
  assign stat.lk_empty  = (lo >= hi);
  assign stat.lk_hit    = (rdata.key == key);

  always_comb begin
    count_next = count;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = carry;
    case (cmd.op)
      DP_CLEAR: begin
        count_next = '0;
      end
      DP_APPEND: begin
        if (!full) begin
          wr_en         = 1'b1;
          wr_addr       = ADDR_W'(count);
          wr_data.key   = item.address;
          wr_data.count = item.packet_count;
          count_next    = count + CNT_W'(1);
        end
      end
      DP_PASS_START: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      DP_PASS_LOAD: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1;
      end
      DP_PASS_STEP: begin
        // carry holds the running maximum; the smaller one settles at idx
        rd_en   = 1'b1;
        rd_addr = idx_p2;
        wr_en   = 1'b1;
        wr_data = swap ? rdata : carry;
      end
      DP_PASS_END: begin
        wr_en = 1'b1;
      end
      DP_LK_PROBE: begin
        rd_en   = 1'b1;
        rd_addr = mid_calc;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_SORT_INIT: begin
        r <= ADDR_W'(count - CNT_W'(1));
      end
      DP_PASS_START: begin
        idx <= '0;
      end
      DP_PASS_LOAD: begin
        carry <= rdata;
      end
      DP_PASS_STEP: begin
        if (!swap) begin
          carry <= rdata;
        end
        idx <= idx_p1;
      end
      DP_PASS_END: begin
        r <= r - ADDR_W'(1);
      end
      DP_LK_INIT: begin
        lo  <= '0;
        hi  <= count;
        key <= item.address;
      end
      DP_LK_PROBE: begin
        mid <= mid_calc;
      end
      DP_LK_CMP: begin
        if (key > rdata.key) begin
          lo <= CNT_W'(mid) + CNT_W'(1);
        end else begin
          hi <= CNT_W'(mid);
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
    if (cmd.fin) begin
      result.found_count <= hit ? rdata.count : 32'd0;
      result.found       <= hit;
      result.entries     <= ENTRY_W'(count_next);
      result.overflow    <= (cmd.op == DP_APPEND) && full;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_PASS_STEP |-> idx < r)
    else $error("sort step past end of pass");
`endif

endmodule

[hw/rtl/sorted_address_count_table.sv]
// Table of up to DEPTH address keys with packet counts. Raise start with an
// item while busy is low; the result beat appears on result with done high
// for exactly one cycle and must be taken then, since there is no back
// pressure. Clear and append finish without leaving idle, so a new item can be
// started in the cycle its result is shown. The table sits in one memory
// with a single read port and registered read data, so every probe or sort
// step waits on a registered read. A lookup over n entries makes at most
// floor(log2 n) + 1 probes. A sort runs bubble passes over r = n-1 down to 1,
// one memory step per pair; sort of fewer than two entries finishes without
// leaving idle. Lookup on an unsorted table runs the same probe sequence on
// the data as held.
module sorted_address_count_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sact_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output sact_pkg::result_t result
);
  import sact_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sact_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sact_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import sact_pkg::*;

  localparam int STALL_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 30;
  localparam int TAIL_CYCLES  = 50;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;

  sorted_address_count_table DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the table
  logic [31:0] shadow_key [DEPTH];
  logic [31:0] shadow_cnt [DEPTH];
  int          shadow_n;

  result_t     expected_q [$];
  int          mismatches;
  int          idle_pct;
  int          items_sent;
  int          quiet_cycles;

  function automatic result_t table_apply(item_t it);
    result_t     r;
    int          lo;
    int          hi;
    int          mid;
    logic [31:0] t;
    r = '0;
    case (it.kind)
      KIND_CLEAR: begin
        shadow_n = 0;
      end
      KIND_APPEND: begin
        if (shadow_n < DEPTH) begin
          shadow_key[shadow_n] = it.address;
          shadow_cnt[shadow_n] = it.packet_count;
          shadow_n++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      KIND_SORT: begin
        for (int p = shadow_n - 1; p > 0; p--) begin
          for (int i = 0; i < p; i++) begin
            if (shadow_key[i] > shadow_key[i+1]) begin
              t = shadow_key[i];
              shadow_key[i] = shadow_key[i+1];
              shadow_key[i+1] = t;
              t = shadow_cnt[i];
              shadow_cnt[i] = shadow_cnt[i+1];
              shadow_cnt[i+1] = t;
            end
          end
        end
      end
      default: begin
        lo = 0;
        hi = shadow_n - 1;
        while (lo <= hi && !r.found) begin
          mid = (lo + hi) / 2;
          if (it.address == shadow_key[mid]) begin
            r.found       = 1'b1;
            r.found_count = shadow_cnt[mid];
          end else if (it.address > shadow_key[mid]) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
    endcase
    r.entries = ENTRY_W'(shadow_n);
    return r;
  endfunction

  // start stays high after a beat so back-to-back items need no extra step
  task automatic send_item(input kind_t k, input logic [31:0] addr, input logic [31:0] cnt);
    item_t it;
    int    gap;
    gap = 0;
    if (idle_pct > 0) begin
      while ($urandom_range(0, 99) < idle_pct && gap < 40) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.kind         = k;
    it.address      = addr;
    it.packet_count = cnt;
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    expected_q.push_back(table_apply(it));
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic report_bad(input string why, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: exp cnt=%h found=%b entries=%0d ovf=%b,",
               $time, why, want.found_count, want.found, want.entries, want.overflow,
               " got cnt=%h found=%b entries=%0d ovf=%b",
               got.found_count, got.found, got.entries, got.overflow);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done !== 1'b0) begin
      if (expected_q.size() == 0) begin
        report_bad("unexpected result", '0, result);
      end else begin
        want = expected_q.pop_front();
        if (result.found_count !== want.found_count || result.found !== want.found ||
            result.entries !== want.entries || result.overflow !== want.overflow) begin
          report_bad("result mismatch", want, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // mix of extremes, a small pool for duplicates, and full-range keys
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] probe_key();
    logic [31:0] k;
    if (shadow_n > 0 && $urandom_range(0, 2) != 0) begin
      k = shadow_key[$urandom_range(0, shadow_n - 1)];
      case ($urandom_range(0, 5))
        0:       return k + 32'd1;
        1:       return k - 32'd1;
        default: return k;
      endcase
    end
    return pick_key();
  endfunction

  task automatic lookup_some(input int n);
    repeat (n) send_item(KIND_LOOKUP, probe_key(), $urandom());
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_item(KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);   // empty table
    send_item(KIND_SORT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(KIND_APPEND, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(KIND_APPEND, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(KIND_APPEND, 32'd5, 32'd0);                   // hit with zero count
    send_item(KIND_APPEND, 32'd5, 32'd7);                   // equal keys keep order
    send_item(KIND_APPEND, 32'd3, 32'd1);
    send_item(KIND_LOOKUP, 32'd3, 32'h0);                   // unsorted table
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_item(KIND_SORT, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'h0000_0000, 32'h0);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_item(KIND_LOOKUP, 32'd5, 32'h0);
    send_item(KIND_LOOKUP, 32'd3, 32'h0);
    send_item(KIND_LOOKUP, 32'd4, 32'h0);
    send_item(KIND_LOOKUP, 32'd6, 32'h0);
    send_item(KIND_CLEAR, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_item(KIND_APPEND, 32'h8000_0000, 32'h1234_5678);
    send_item(KIND_SORT, 32'h0, 32'h0);                    // single entry
    send_item(KIND_LOOKUP, 32'h8000_0000, 32'h0);
    send_item(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_item(KIND_CLEAR, 32'h0, 32'h0);
    send_item(KIND_LOOKUP, 32'h8000_0000, 32'h0);
  endtask

  task automatic test_full_table();
    logic [31:0] k;
    idle_pct = 30;
    send_item(KIND_CLEAR, $urandom(), $urandom());
    // ascending keys so lookups are meaningful without a full-size sort
    for (int i = 0; i < DEPTH; i++) begin
      k = i;
      k = k * 32'd4000000 + $urandom_range(0, 3999999);
      send_item(KIND_APPEND, k, $urandom());
    end
    send_item(KIND_APPEND, 32'hFFFF_FFFF, $urandom());
    send_item(KIND_APPEND, $urandom(), $urandom());
    send_item(KIND_LOOKUP, shadow_key[0], $urandom());
    send_item(KIND_LOOKUP, shadow_key[DEPTH-1], $urandom());
    send_item(KIND_LOOKUP, 32'h0000_0000, $urandom());
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, $urandom());
    lookup_some(12);
    send_item(KIND_CLEAR, $urandom(), $urandom());
    send_item(KIND_LOOKUP, $urandom(), $urandom());
  endtask

  task automatic test_sort_large();
    idle_pct = 66;
    send_item(KIND_CLEAR, $urandom(), $urandom());
    repeat (40) send_item(KIND_APPEND, pick_key(), $urandom());
    send_item(KIND_SORT, $urandom(), $urandom());
    lookup_some(8);
  endtask

  task automatic test_random();
    int       first;
    int       sess;
    int       phase_pct;
    logic [1:0] k;
    first = items_sent;
    sess  = 0;
    while (items_sent - first < RANDOM_ITEMS) begin
      case ((items_sent - first) * 3 / RANDOM_ITEMS)
        0:       phase_pct = 0;
        1:       phase_pct = 66;
        default: phase_pct = 30;
      endcase
      idle_pct = (sess % 4 == 3) ? 0 : phase_pct;
      if (shadow_n > 60) send_item(KIND_CLEAR, $urandom(), $urandom());
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          if ($urandom_range(0, 2) == 0) send_item(KIND_CLEAR, $urandom(), $urandom());
          repeat ($urandom_range(1, 24)) send_item(KIND_APPEND, pick_key(), $urandom());
          if ($urandom_range(0, 9) != 0) send_item(KIND_SORT, $urandom(), $urandom());
          lookup_some($urandom_range(2, 8));
        end
        7, 8: begin
          // lookups on data that is not (or no longer) sorted
          repeat ($urandom_range(1, 10)) send_item(KIND_APPEND, pick_key(), $urandom());
          lookup_some($urandom_range(1, 5));
          if ($urandom_range(0, 1) == 0) send_item(KIND_SORT, $urandom(), $urandom());
          repeat ($urandom_range(1, 4)) send_item(KIND_APPEND, pick_key(), $urandom());
          lookup_some($urandom_range(1, 5));
        end
        default: begin
          repeat ($urandom_range(3, 12)) begin
            k = $urandom_range(0, 3);
            send_item(kind_t'(k), pick_key(), $urandom());
          end
        end
      endcase
      if (sess % 7 == 6) drain();
      sess++;
    end
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    item       <= '0;
    mismatches = 0;
    idle_pct   = 0;
    items_sent = 0;
    shadow_n   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    drain();
    test_full_table();
    drain();
    test_sort_large();
    drain();
    test_random();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
